// ----- rtl/core/rscf_pkg.sv -----
// ----------------------------------------------------------------------------
// rscf_pkg: shared types and constants of the remote switch frame sender
// Holds the sequencer mode type, the frame constants and the code tables
// that turn house, unit and command into the 16-bit command word.
// ----------------------------------------------------------------------------
package rscf_pkg;

  // Field widths of the input and result words.
  localparam int unsigned HouseW  = 4;
  localparam int unsigned UnitW   = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned GapW    = 12;
  localparam int unsigned FrameW  = 40;
  localparam int unsigned BitsW   = 6;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // Frame framing bytes and timing defaults.
  localparam logic [7:0]       FrameHdr0  = 8'hD5;
  localparam logic [7:0]       FrameHdr1  = 8'hAA;
  localparam logic [7:0]       FrameFtr   = 8'hAD;
  localparam logic [BitsW-1:0] FrameBits  = 6'd40;
  localparam logic [GapW-1:0]  GapReset   = 12'd1000;
  localparam logic [1:0]       LeadStart  = 2'd1;

  // Command codes.
  localparam logic [CmdW-1:0] CmdOn     = 2'd0;
  localparam logic [CmdW-1:0] CmdOff    = 2'd1;
  localparam logic [CmdW-1:0] CmdBright = 2'd2;
  localparam logic [CmdW-1:0] CmdDim    = 2'd3;

  // Sequencer modes.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LEAD = 2'd1,
    MODE_BITS = 2'd2,
    MODE_GAP  = 2'd3
  } mode_t;

  // House letter to the upper nibble of the command word.
  function automatic logic [15:0] house_code(input logic [HouseW-1:0] h);
    logic [15:0] c;
    case (h)
      4'd0:    c = 16'h6000;
      4'd1:    c = 16'h7000;
      4'd2:    c = 16'h4000;
      4'd3:    c = 16'h5000;
      4'd4:    c = 16'h8000;
      4'd5:    c = 16'h9000;
      4'd6:    c = 16'hA000;
      4'd7:    c = 16'hB000;
      4'd8:    c = 16'hE000;
      4'd9:    c = 16'hF000;
      4'd10:   c = 16'hC000;
      4'd11:   c = 16'hD000;
      4'd12:   c = 16'h0000;
      4'd13:   c = 16'h1000;
      4'd14:   c = 16'h2000;
      4'd15:   c = 16'h3000;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // Unit number to its scattered bits in the command word.
  function automatic logic [15:0] unit_code(input logic [UnitW-1:0] u);
    logic [15:0] c;
    case (u)
      4'd0:    c = 16'h0000;
      4'd1:    c = 16'h0010;
      4'd2:    c = 16'h0008;
      4'd3:    c = 16'h0018;
      4'd4:    c = 16'h0040;
      4'd5:    c = 16'h0050;
      4'd6:    c = 16'h0048;
      4'd7:    c = 16'h0058;
      4'd8:    c = 16'h0400;
      4'd9:    c = 16'h0410;
      4'd10:   c = 16'h0408;
      4'd11:   c = 16'h0418;
      4'd12:   c = 16'h0440;
      4'd13:   c = 16'h0450;
      4'd14:   c = 16'h0448;
      4'd15:   c = 16'h0458;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // Command to its bits in the command word.
  function automatic logic [15:0] cmd_code(input logic [CmdW-1:0] k);
    logic [15:0] c;
    case (k)
      CmdOn:     c = 16'h0000;
      CmdOff:    c = 16'h0020;
      CmdBright: c = 16'h0088;
      CmdDim:    c = 16'h0098;
      default:   c = 16'h0000;
    endcase
    return c;
  endfunction

  // Full command word; brighten and dim carry no unit bits.
  function automatic logic [15:0] make_word(input logic [HouseW-1:0] h,
                                            input logic [UnitW-1:0]  u,
                                            input logic [CmdW-1:0]   k);
    logic [15:0] w;
    w = house_code(h) | cmd_code(k);
    if (k == CmdOn || k == CmdOff) begin
      w = w | unit_code(u);
    end
    return w;
  endfunction

endpackage

// ----- rtl/core/remote_switch_command_frame_sender_core.sv -----
// ----------------------------------------------------------------------------
// remote_switch_command_frame_sender_core: two-wire command frame sender
// Each input word is one half-bit tick. On a start request while idle the
// command word is built and a 40-bit frame is sent on the RTS/DTR pair,
// followed by a programmable standby gap. One result word per tick.
//
//   Channel  Direction  Payload (low bit first)
//   in_      slave      start_req, house[3:0], unit[3:0], command[1:0]
//   out_     master     rts_line, dtr_line, busy_res, accepted
//   cfg_     write      gap_ticks[11:0]
//
// A new word can be accepted in every cycle while the skid register is empty.
// The sequencer registers and a two-entry result buffer (output register
// plus skid register) are the only storage on the path.
// in_tready drops only while the skid register is full, i.e. while two
// result words wait behind a stalled result side.
// Reset (synchronous, rst_n low) returns to idle with gap_ticks = 1000.
// ----------------------------------------------------------------------------
module remote_switch_command_frame_sender_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input words.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] start_req, [4:1] house, [8:5] unit, [10:9] command, [15:11] zero
  input  logic [rscf_pkg::InDataW-1:0]       in_tdata,
  // Result words.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] rts_line, [1] dtr_line, [2] busy_res, [3] accepted, [7:4] zero
  output logic [rscf_pkg::OutDataW-1:0]      out_tdata,
  // Gap length register.
  input  logic                               cfg_wr_en,
  input  logic [rscf_pkg::GapW-1:0]          cfg_wr_data
);
  import rscf_pkg::*;

  // Sequencer state.
  mode_t              mode_r, mode_nxt;
  logic [FrameW-1:0]  frame_shift_r, frame_shift_nxt;
  logic [BitsW-1:0]   bits_left_r, bits_left_nxt;
  logic               half_phase_r, half_phase_nxt;
  logic [1:0]         lead_count_r, lead_count_nxt;
  logic [GapW-1:0]    gap_count_r, gap_count_nxt;
  logic [GapW-1:0]    gap_ticks_r;

  // Result buffer.
  logic                out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0] out_data_r, out_data_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  logic [OutDataW-1:0] skid_data_r, skid_data_nxt;

  // Unpacked input fields and the result of this tick.
  logic               in_accept;
  logic               start_req;
  logic [HouseW-1:0]  house;
  logic [UnitW-1:0]   unit;
  logic [CmdW-1:0]    command;
  logic               rts, dtr, busy, acc;
  logic [BitsW-1:0]   bits_dec;
  logic [15:0]        word;

  assign in_tready  = !skid_valid_r;
  assign in_accept  = in_tvalid && in_tready;
  assign start_req  = in_tdata[0];
  assign house      = in_tdata[4:1];
  assign unit       = in_tdata[8:5];
  assign command    = in_tdata[10:9];
  assign word       = make_word(house, unit, command);
  assign bits_dec   = bits_left_r - 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Tick sequencer: line levels and next state for the current word.
  always_comb begin
    rts             = 1'b1;
    dtr             = 1'b1;
    busy            = 1'b1;
    acc             = 1'b0;
    mode_nxt        = mode_r;
    frame_shift_nxt = frame_shift_r;
    bits_left_nxt   = bits_left_r;
    half_phase_nxt  = half_phase_r;
    lead_count_nxt  = lead_count_r;
    gap_count_nxt   = gap_count_r;
    case (mode_r)
      MODE_LEAD: begin
        lead_count_nxt = lead_count_r - 1'b1;
        if (lead_count_nxt == 2'd0) begin
          mode_nxt       = MODE_BITS;
          half_phase_nxt = 1'b0;
        end
      end
      MODE_BITS: begin
        if (bits_left_r == '0 || (half_phase_r && bits_dec == '0)) begin
          // End of frame: start the gap, or go idle on a zero gap.
          if (gap_ticks_r == '0) begin
            mode_nxt = MODE_IDLE;
          end else begin
            gap_count_nxt = gap_ticks_r;
            mode_nxt      = MODE_GAP;
          end
        end
        if (bits_left_r != '0) begin
          if (!half_phase_r) begin
            // Data half of the bit.
            rts            = frame_shift_r[FrameW-1];
            dtr            = !frame_shift_r[FrameW-1];
            half_phase_nxt = 1'b1;
          end else begin
            // Standby half, then move to the next bit.
            half_phase_nxt  = 1'b0;
            frame_shift_nxt = {frame_shift_r[FrameW-2:0], 1'b0};
            bits_left_nxt   = bits_dec;
          end
        end
      end
      MODE_GAP: begin
        gap_count_nxt = gap_count_r - 1'b1;
        if (gap_count_nxt == '0) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (start_req) begin
          frame_shift_nxt = {FrameHdr0, FrameHdr1, word, FrameFtr};
          bits_left_nxt   = FrameBits;
          half_phase_nxt  = 1'b0;
          lead_count_nxt  = LeadStart;
          mode_nxt        = MODE_LEAD;
          acc             = 1'b1;
        end else begin
          busy = 1'b0;
        end
      end
    endcase
  end

  // Result buffer: output register with a skid register behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_accept;
        out_data_nxt  = {4'b0000, acc, busy, dtr, rts};
      end
    end else if (in_accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = {4'b0000, acc, busy, dtr, rts};
    end
  end

  // Control and sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      frame_shift_r <= '0;
      bits_left_r   <= '0;
      half_phase_r  <= 1'b0;
      lead_count_r  <= '0;
      gap_count_r   <= '0;
      gap_ticks_r   <= GapReset;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_r        <= mode_nxt;
        frame_shift_r <= frame_shift_nxt;
        bits_left_r   <= bits_left_nxt;
        half_phase_r  <= half_phase_nxt;
        lead_count_r  <= lead_count_nxt;
        gap_count_r   <= gap_count_nxt;
      end
      if (cfg_wr_en) begin
        gap_ticks_r <= cfg_wr_data;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTHESIS
  // The skid register only fills behind a held output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // A shown word never drives both lines low.
  a_lines_never_both_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[0] || out_data_r[1]))
    else $error("RTS and DTR both low");

  // An accepted request is always reported as busy.
  a_accept_is_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[3]) |-> out_data_r[2])
    else $error("accepted word without busy");

  // A start request taken while idle enters the lead phase.
  a_start_to_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && mode_r == MODE_IDLE && start_req) |=> mode_r == MODE_LEAD)
    else $error("start request did not enter lead phase");

  // The bit counter is never empty while bits are being sent.
  a_bits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_BITS) |-> (bits_left_r != '0))
    else $error("bit counter empty in bit phase");
`endif

endmodule
